// ===== sv/scc_pkg.sv =====
package scc_pkg;

  localparam int ENTRIES = 12;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int TAG_W   = 32;
  localparam int KIND_W  = 2;
  localparam int SLOT_W  = 4;
  localparam int OUT_W   = SLOT_W + 3 + TAG_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ     = 2'd0,
    KIND_WRITE    = 2'd1,
    KIND_PREFETCH = 2'd2,
    KIND_FLUSH    = 2'd3
  } kind_e;

  // update request from the sequencer to the slot status bits
  typedef struct packed {
    logic             upd;
    logic             fill;
    logic             acc;
    logic             dirty;
    logic             sweep;
    logic             flush_clr;
    logic [IDX_W-1:0] idx;
  } meta_cmd_t;

  // slot status seen by the sequencer
  typedef struct packed {
    logic [ENTRIES-1:0] valid;
    logic [ENTRIES-1:0] dirty;
    logic [IDX_W-1:0]   hand;
    logic               acc_at_hand;
    logic               free_any;
    logic [IDX_W-1:0]   free_idx;
    logic               pend_any;
    logic [IDX_W-1:0]   pend_idx;
  } meta_sts_t;

  // slot number as reported, wraps for more than sixteen slots
  function automatic logic [SLOT_W-1:0] slot_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+SLOT_W-1:0] w;
    w = (IDX_W + SLOT_W)'(idx);
    return w[SLOT_W-1:0];
  endfunction

endpackage

// ===== sv/sector_cache_clock_replacement.sv =====
// channel   | signals                                   | contents
// s_axis    | tvalid/tready, tdata[31:0], tuser[1:0]    | request: sector, kind
// m_axis    | tvalid/tready, tdata[39:0], tlast         | result per slot, tlast on final
//
// one request at a time; tags sit in a single-port-read ram, slot bits in flops
// lookup: tag scan over all ENTRIES slots (one ram read per cycle), a hit
//   ends it early; a miss adds a pick step, and with every slot taken also
//   sweep steps plus one victim tag read; the accept comes first and the
//   result load last
// flush: per dirty slot a select, a tag read and a result load; if none is
//   dirty, a select and one empty result load; the accept comes first
// reset clears slot status and clock hand at once; tags need no clearing
// a stalled result holds the engine at its result load; the next request is
//   taken while the previous result still waits in the output register
module sector_cache_clock_replacement import scc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [TAG_W-1:0]       s_axis_tdata_i,  // sector
  input  logic [KIND_W-1:0]      s_axis_tuser_i,  // kind
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // slot[3:0], hit[4], fill_needed[5], writeback_needed[6],
  // writeback_sector[38:7], zero pad[39]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  output logic                   m_axis_tlast_o   // last
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_SCAN  = 8'b0000_0010,
    ST_PICK  = 8'b0000_0100,
    ST_SWEEP = 8'b0000_1000,
    ST_VREAD = 8'b0001_0000,
    ST_FLUSH = 8'b0010_0000,
    ST_FLRD  = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e             state_q, state_d;
  kind_e              kind_q, kind_d;
  logic [TAG_W-1:0]   sector_q, sector_d;
  logic [IDX_W-1:0]   slot_q, slot_d;
  logic               hit_q, hit_d;
  logic               fill_q, fill_d;
  logic               wb_q, wb_d;
  logic [TAG_W-1:0]   wbsec_q, wbsec_d;
  logic               last_q, last_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]   cmp_idx_q, cmp_idx_d;

  logic               out_vld_q;
  logic [OUT_W-1:0]   out_data_q;
  logic               out_last_q;
  logic               out_load;

  logic               ram_we;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [TAG_W-1:0]   ram_rdata;

  meta_cmd_t          cmd;
  meta_sts_t          sts;

  scc_ram #(
    .WIDTH (TAG_W),
    .DEPTH (ENTRIES)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_q),
    .wdata_i (sector_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  scc_meta u_meta (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    sector_d  = sector_q;
    slot_d    = slot_q;
    hit_d     = hit_q;
    fill_d    = fill_q;
    wb_d      = wb_q;
    wbsec_d   = wbsec_q;
    last_d    = last_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    out_load  = 1'b0;
    cmd       = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          kind_d   = kind_e'(s_axis_tuser_i);
          sector_d = s_axis_tdata_i;
          slot_d   = '0;
          hit_d    = 1'b0;
          fill_d   = 1'b0;
          wb_d     = 1'b0;
          wbsec_d  = '0;
          last_d   = 1'b1;
          cnt_d    = '0;
          state_d  = (kind_e'(s_axis_tuser_i) == KIND_FLUSH) ? ST_FLUSH : ST_SCAN;
        end
      end
      // read one tag per cycle, compare the one read the cycle before
      ST_SCAN: begin
        if (cnt_q < CNT_W'(ENTRIES)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[IDX_W-1:0];
          cmp_vld_d = 1'b1;
          cmp_idx_d = cnt_q[IDX_W-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        if (cmp_vld_q && sts.valid[cmp_idx_q] && (ram_rdata == sector_q)) begin
          hit_d   = 1'b1;
          slot_d  = cmp_idx_q;
          state_d = ST_EMIT;
        end else if (cnt_q == CNT_W'(ENTRIES)) begin
          state_d = ST_PICK;
        end
      end
      ST_PICK: begin
        fill_d = 1'b1;
        if (sts.free_any) begin
          slot_d  = sts.free_idx;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      // every slot is valid here: give second chances until a clear access bit
      ST_SWEEP: begin
        if (sts.acc_at_hand) begin
          cmd.sweep = 1'b1;
        end else begin
          slot_d    = sts.hand;
          ram_re    = 1'b1;
          ram_raddr = sts.hand;
          state_d   = ST_VREAD;
        end
      end
      ST_VREAD: begin
        wb_d    = sts.dirty[slot_q];
        wbsec_d = sts.dirty[slot_q] ? ram_rdata : '0;
        state_d = ST_EMIT;
      end
      ST_FLUSH: begin
        if (sts.pend_any) begin
          slot_d        = sts.pend_idx;
          ram_re        = 1'b1;
          ram_raddr     = sts.pend_idx;
          cmd.flush_clr = 1'b1;
          cmd.idx       = sts.pend_idx;
          state_d       = ST_FLRD;
        end else begin
          // nothing dirty: single empty result
          slot_d  = '0;
          wb_d    = 1'b0;
          wbsec_d = '0;
          last_d  = 1'b1;
          state_d = ST_EMIT;
        end
      end
      ST_FLRD: begin
        wb_d    = 1'b1;
        wbsec_d = ram_rdata;
        last_d  = ~sts.pend_any;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_vld_q || m_axis_tready_i) begin
          out_load = 1'b1;
          if (kind_q != KIND_FLUSH) begin
            cmd.upd   = 1'b1;
            cmd.fill  = fill_q;
            cmd.acc   = (kind_q == KIND_READ) || (kind_q == KIND_WRITE);
            cmd.dirty = (kind_q == KIND_WRITE);
            cmd.idx   = slot_q;
            ram_we    = fill_q;
          end
          state_d = ((kind_q == KIND_FLUSH) && !last_q) ? ST_FLUSH : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cmp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    sector_q  <= sector_d;
    slot_q    <= slot_d;
    hit_q     <= hit_d;
    fill_q    <= fill_d;
    wb_q      <= wb_d;
    wbsec_q   <= wbsec_d;
    last_q    <= last_d;
    cnt_q     <= cnt_d;
    cmp_idx_q <= cmp_idx_d;
    if (out_load) begin
      out_data_q <= {wbsec_q, wb_q, fill_q, hit_q, slot_out(slot_q)};
      out_last_q <= last_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(out_data_q);
  assign m_axis_tlast_o  = out_last_q;

endmodule

// ===== sv/scc_ram.sv =====
module scc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scc_meta.sv =====
module scc_meta import scc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  meta_cmd_t cmd_i,
  output meta_sts_t sts_o
);

  logic [ENTRIES-1:0] valid_q;
  logic [ENTRIES-1:0] acc_q;
  logic [ENTRIES-1:0] dirty_q;
  logic [IDX_W-1:0]   hand_q;
  logic [IDX_W-1:0]   hand_nxt;
  logic [ENTRIES-1:0] pend;

  assign hand_nxt = (hand_q == IDX_W'(ENTRIES - 1)) ? '0 : hand_q + 1'b1;
  assign pend     = valid_q & dirty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      acc_q   <= '0;
      dirty_q <= '0;
      hand_q  <= '0;
    end else begin
      if (cmd_i.upd) begin
        valid_q[cmd_i.idx] <= 1'b1;
        acc_q[cmd_i.idx]   <= cmd_i.acc | (acc_q[cmd_i.idx] & ~cmd_i.fill);
        dirty_q[cmd_i.idx] <= cmd_i.dirty | (dirty_q[cmd_i.idx] & ~cmd_i.fill);
      end
      if (cmd_i.sweep) begin
        acc_q[hand_q] <= 1'b0;
        hand_q        <= hand_nxt;
      end
      if (cmd_i.flush_clr) begin
        dirty_q[cmd_i.idx] <= 1'b0;
      end
    end
  end

  // lowest free slot and lowest pending write-back
  always_comb begin
    sts_o.valid       = valid_q;
    sts_o.dirty       = dirty_q;
    sts_o.hand        = hand_q;
    sts_o.acc_at_hand = acc_q[hand_q];
    sts_o.free_any    = ~&valid_q;
    sts_o.pend_any    = |pend;
    sts_o.free_idx    = '0;
    sts_o.pend_idx    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        sts_o.free_idx = IDX_W'(i);
      end
      if (pend[i]) begin
        sts_o.pend_idx = IDX_W'(i);
      end
    end
  end

endmodule

// ===== sv/scc_checker.sv =====
module scc_checker import scc_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_i,
  input logic [TAG_W-1:0]       s_axis_tdata_i,
  input logic [KIND_W-1:0]      s_axis_tuser_i,
  input logic                   m_axis_tvalid_i,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_i,
  input logic                   m_axis_tlast_i
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))
    else $error("result changed while stalled");

  // a waiting request holds its fields
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && !s_axis_tready_i |=>
      s_axis_tvalid_i && $stable(s_axis_tdata_i) && $stable(s_axis_tuser_i))
    else $error("request changed while waiting");

  // one request in flight: ready drops after a transaction
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_i |=> !s_axis_tready_i)
    else $error("request taken while busy");

  // a hit never needs a fill or a write-back
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tdata_i[4] |-> !m_axis_tdata_i[5] && !m_axis_tdata_i[6])
    else $error("hit with fill or write-back");

  // lookups give one result, so a result without tlast is a flush write-back
  a_flush_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tlast_i |->
      m_axis_tdata_i[6] && !m_axis_tdata_i[5] && !m_axis_tdata_i[4])
    else $error("non-final result that is not a write-back");

endmodule

bind sector_cache_clock_replacement scc_checker u_scc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_i (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);
